FILE: sv/lvts_pkg.sv
// Shared types, codes and defaults for the leveled task slot table.
package lvts_pkg;

  localparam int SLOTS_PER_GROUP_DEF = 16;
  localparam int LEVEL0_GROUPS_DEF = 2;
  localparam int LEVEL1_GROUPS_DEF = 2;
  localparam int LEVEL2_GROUPS_DEF = 2;
  localparam int LEVEL3_GROUPS_DEF = 2;
  localparam int TASK_ID_BITS_DEF = 16;

  localparam logic [3:0] TOTAL_GROUPS_RST = 4'd8;

  localparam logic [31:0] DLY_COUNT_MASK = 32'h0000_7FFF;
  localparam logic [31:0] DLY_DONE_BIT = 32'h0000_8000;
  localparam logic [31:0] DLY_STAMP_MASK = 32'hFFFF_0000;
  localparam int DLY_STAMP_SHIFT = 16;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_DEL,
    CMD_DELAY
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_BAD_LEVEL
  } status_t;

  typedef enum logic [2:0] {
    LVL_0,
    LVL_1,
    LVL_2,
    LVL_3
  } level_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MASK_RD,
    S_MASK_CHK,
    S_SCAN,
    S_ID_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  group_index;
    logic [3:0]  slot_index;
    logic [31:0] delay_word;
  } res_t;

  function automatic logic [4:0] lowest_bit(input logic [31:0] w);
    logic [4:0] n;
    n = '0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

endpackage

FILE: sv/lvts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lvts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lvts_delay.sv
// Delay record stamping and elapsed-time check against the ticker.
module lvts_delay (
  input  logic [15:0] ticker,
  input  logic [31:0] dw_in,
  output logic [31:0] dw_out
);

  logic [31:0] stamped;
  logic [15:0] stamp;
  logic [15:0] elapsed;

  always_comb begin
    stamped = dw_in;
    if ((dw_in & lvts_pkg::DLY_STAMP_MASK) == '0) begin
      stamped = dw_in | ({16'b0, ticker} << lvts_pkg::DLY_STAMP_SHIFT);
    end
    stamp = stamped[31:16];
    elapsed = ticker - stamp;
    dw_out = stamped;
    if ({16'b0, elapsed} >= (stamped & lvts_pkg::DLY_COUNT_MASK)) begin
      dw_out = stamped | lvts_pkg::DLY_DONE_BIT;
    end
  end

endmodule

FILE: sv/lvts_engine.sv
// Command sequencer with the group mask memory and the slot record memory.
module lvts_engine #(
  parameter int SLOTS_PER_GROUP = lvts_pkg::SLOTS_PER_GROUP_DEF,
  parameter int LEVEL0_GROUPS = lvts_pkg::LEVEL0_GROUPS_DEF,
  parameter int LEVEL1_GROUPS = lvts_pkg::LEVEL1_GROUPS_DEF,
  parameter int LEVEL2_GROUPS = lvts_pkg::LEVEL2_GROUPS_DEF,
  parameter int LEVEL3_GROUPS = lvts_pkg::LEVEL3_GROUPS_DEF,
  parameter int TASK_ID_BITS = lvts_pkg::TASK_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        total_groups,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [2:0]        level,
  input  logic [15:0]       task_id,
  input  logic [15:0]       period,
  input  logic [15:0]       start_offset,
  input  logic [31:0]       delay_word,
  output logic              res_valid,
  input  logic              res_ready,
  output lvts_pkg::res_t    res
);

  localparam int ALL_GROUPS = LEVEL0_GROUPS + LEVEL1_GROUPS + LEVEL2_GROUPS + LEVEL3_GROUPS;
  localparam int ALL_SLOTS = ALL_GROUPS * SLOTS_PER_GROUP;
  localparam int GRP_W = ALL_GROUPS > 1 ? $clog2(ALL_GROUPS) : 1;
  localparam int SLOT_W = SLOTS_PER_GROUP > 1 ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int ADDR_W = ALL_SLOTS > 1 ? $clog2(ALL_SLOTS) : 1;
  localparam int MASK_W = 3 * SLOTS_PER_GROUP;
  localparam int REC_W = TASK_ID_BITS + 32;
  localparam logic [SLOTS_PER_GROUP-1:0] ONE_BIT = SLOTS_PER_GROUP'(1);

  localparam logic [GRP_W-1:0] L3_FIRST = GRP_W'(0);
  localparam logic [GRP_W-1:0] L3_LAST = GRP_W'(LEVEL3_GROUPS - 1);
  localparam logic [GRP_W-1:0] L2_FIRST = GRP_W'(LEVEL3_GROUPS);
  localparam logic [GRP_W-1:0] L2_LAST = GRP_W'(LEVEL3_GROUPS + LEVEL2_GROUPS - 1);
  localparam logic [GRP_W-1:0] L1_FIRST = GRP_W'(LEVEL3_GROUPS + LEVEL2_GROUPS);
  localparam logic [GRP_W-1:0] L1_LAST =
    GRP_W'(LEVEL3_GROUPS + LEVEL2_GROUPS + LEVEL1_GROUPS - 1);
  localparam logic [GRP_W-1:0] L0_FIRST =
    GRP_W'(LEVEL3_GROUPS + LEVEL2_GROUPS + LEVEL1_GROUPS);
  localparam logic [GRP_W-1:0] L0_LAST = GRP_W'(ALL_GROUPS - 1);

  lvts_pkg::state_t state, state_next;

  lvts_pkg::cmd_t           cmd_r;
  logic [2:0]               level_r;
  logic [TASK_ID_BITS-1:0]  id_r;
  logic [15:0]              period_r;
  logic [15:0]              offset_r;
  logic [31:0]              dw_r;
  logic [15:0]              ticker;
  logic [GRP_W-1:0]         g;
  logic [GRP_W-1:0]         g_last;
  logic [SLOTS_PER_GROUP-1:0] left;
  logic [MASK_W-1:0]        mask_word;
  logic [SLOT_W-1:0]        cur_s;
  logic [ALL_GROUPS-1:0]    grp_valid;
  logic                     mask_rd_ok;

  logic                     mask_we;
  logic [MASK_W-1:0]        mask_wdata;
  logic                     mask_re;
  logic [MASK_W-1:0]        mask_rdata;
  logic [MASK_W-1:0]        mask_cur;
  logic                     slot_we;
  logic [ADDR_W-1:0]        slot_waddr;
  logic [REC_W-1:0]         slot_wdata;
  logic                     slot_re;
  logic [ADDR_W-1:0]        slot_raddr;
  logic [REC_W-1:0]         slot_rdata;

  logic [SLOTS_PER_GROUP-1:0] occ;
  logic [SLOTS_PER_GROUP-1:0] unst;
  logic [SLOTS_PER_GROUP-1:0] act;
  logic [SLOTS_PER_GROUP-1:0] free_bits;
  logic [SLOT_W-1:0]        low_free;
  logic [SLOT_W-1:0]        low_left;
  logic [SLOTS_PER_GROUP-1:0] free_bit;
  logic [SLOTS_PER_GROUP-1:0] cur_bit;
  logic                     mark_unst;
  logic                     lvl_ok;
  logic [GRP_W-1:0]         lvl_first;
  logic [GRP_W-1:0]         lvl_last;
  logic                     id_match;
  logic [31:0]              dly_out;

  lvts_ram #(
    .WIDTH(MASK_W),
    .DEPTH(ALL_GROUPS)
  ) u_mask_ram (
    .clk  (clk),
    .we   (mask_we),
    .waddr(g),
    .wdata(mask_wdata),
    .re   (mask_re),
    .raddr(g),
    .rdata(mask_rdata)
  );

  lvts_ram #(
    .WIDTH(REC_W),
    .DEPTH(ALL_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  lvts_delay u_delay (
    .ticker(ticker),
    .dw_in (dw_r),
    .dw_out(dly_out)
  );

  always_comb begin
    lvl_ok = 1'b1;
    lvl_first = L3_FIRST;
    lvl_last = L3_LAST;
    case (level_r)
      lvts_pkg::LVL_3: begin
        lvl_first = L3_FIRST;
        lvl_last = L3_LAST;
      end
      lvts_pkg::LVL_2: begin
        lvl_first = L2_FIRST;
        lvl_last = L2_LAST;
      end
      lvts_pkg::LVL_1: begin
        lvl_first = L1_FIRST;
        lvl_last = L1_LAST;
      end
      lvts_pkg::LVL_0: begin
        lvl_first = L0_FIRST;
        lvl_last = L0_LAST;
      end
      default: begin
        lvl_ok = 1'b0;
      end
    endcase
  end

  // Groups never written since reset read as empty.
  assign mask_cur = mask_rd_ok ? mask_rdata : '0;
  assign occ = mask_cur[SLOTS_PER_GROUP-1:0];
  assign unst = mask_cur[2*SLOTS_PER_GROUP-1:SLOTS_PER_GROUP];
  assign act = mask_cur[MASK_W-1:2*SLOTS_PER_GROUP];
  assign free_bits = ~occ;
  assign low_free = SLOT_W'(lvts_pkg::lowest_bit(32'(free_bits)));
  assign low_left = SLOT_W'(lvts_pkg::lowest_bit(32'(left)));
  assign free_bit = ONE_BIT << low_free;
  assign cur_bit = ONE_BIT << cur_s;
  assign mark_unst = (7'(g) + 7'(LEVEL0_GROUPS)) < 7'(total_groups);
  assign id_match = slot_rdata[REC_W-1 -: TASK_ID_BITS] == id_r;

  assign slot_waddr = ADDR_W'(int'(g) * SLOTS_PER_GROUP + int'(low_free));
  assign slot_raddr = ADDR_W'(int'(g) * SLOTS_PER_GROUP + int'(low_left));
  assign slot_wdata = {id_r, period_r, ticker + offset_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lvts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    res_valid = 1'b0;
    mask_re = 1'b0;
    mask_we = 1'b0;
    mask_wdata = {act, unst, occ};
    slot_we = 1'b0;
    slot_re = 1'b0;
    case (state)
      lvts_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = lvts_pkg::S_EXEC;
        end
      end
      lvts_pkg::S_EXEC: begin
        if (cmd_r == lvts_pkg::CMD_TICK || cmd_r == lvts_pkg::CMD_DELAY || !lvl_ok) begin
          state_next = lvts_pkg::S_DONE;
        end else begin
          state_next = lvts_pkg::S_MASK_RD;
        end
      end
      lvts_pkg::S_MASK_RD: begin
        mask_re = 1'b1;
        state_next = lvts_pkg::S_MASK_CHK;
      end
      lvts_pkg::S_MASK_CHK: begin
        if (cmd_r == lvts_pkg::CMD_ADD) begin
          if (free_bits != '0) begin
            mask_we = 1'b1;
            mask_wdata = {act, mark_unst ? (unst | free_bit) : unst, occ | free_bit};
            slot_we = 1'b1;
            state_next = lvts_pkg::S_DONE;
          end else if (g == g_last) begin
            state_next = lvts_pkg::S_DONE;
          end else begin
            state_next = lvts_pkg::S_MASK_RD;
          end
        end else begin
          state_next = lvts_pkg::S_SCAN;
        end
      end
      lvts_pkg::S_SCAN: begin
        if (left == '0) begin
          if (g == g_last) begin
            state_next = lvts_pkg::S_DONE;
          end else begin
            state_next = lvts_pkg::S_MASK_RD;
          end
        end else begin
          slot_re = 1'b1;
          state_next = lvts_pkg::S_ID_CHK;
        end
      end
      lvts_pkg::S_ID_CHK: begin
        if (id_match) begin
          mask_we = 1'b1;
          mask_wdata = {mask_word[MASK_W-1:2*SLOTS_PER_GROUP] & ~cur_bit,
                        mask_word[2*SLOTS_PER_GROUP-1:SLOTS_PER_GROUP],
                        mask_word[SLOTS_PER_GROUP-1:0] & ~cur_bit};
          state_next = lvts_pkg::S_DONE;
        end else begin
          state_next = lvts_pkg::S_SCAN;
        end
      end
      lvts_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = lvts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lvts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticker <= '0;
      grp_valid <= '0;
    end else begin
      case (state)
        lvts_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r <= lvts_pkg::cmd_t'(cmd);
            level_r <= level;
            id_r <= TASK_ID_BITS'(task_id);
            period_r <= period;
            offset_r <= start_offset;
            dw_r <= delay_word;
          end
        end
        lvts_pkg::S_EXEC: begin
          res <= '{status: (cmd_r != lvts_pkg::CMD_TICK && cmd_r != lvts_pkg::CMD_DELAY &&
                            !lvl_ok) ? lvts_pkg::ST_BAD_LEVEL : lvts_pkg::ST_OK,
                   group_index: '0, slot_index: '0,
                   delay_word: (cmd_r == lvts_pkg::CMD_DELAY) ? dly_out : '0};
          if (cmd_r == lvts_pkg::CMD_TICK) begin
            ticker <= ticker + 16'd1;
          end else if (cmd_r != lvts_pkg::CMD_DELAY && lvl_ok) begin
            g <= lvl_first;
            g_last <= lvl_last;
          end
        end
        lvts_pkg::S_MASK_RD: begin
          mask_rd_ok <= grp_valid[g];
        end
        lvts_pkg::S_MASK_CHK: begin
          if (cmd_r == lvts_pkg::CMD_ADD) begin
            if (free_bits != '0) begin
              grp_valid[g] <= 1'b1;
              res.group_index <= 3'(g);
              res.slot_index <= 4'(low_free);
            end else if (g == g_last) begin
              res.status <= lvts_pkg::ST_FULL;
            end else begin
              g <= g + GRP_W'(1);
            end
          end else begin
            left <= occ;
            mask_word <= mask_cur;
          end
        end
        lvts_pkg::S_SCAN: begin
          if (left == '0) begin
            if (g == g_last) begin
              res.status <= lvts_pkg::ST_NOT_FOUND;
            end else begin
              g <= g + GRP_W'(1);
            end
          end else begin
            cur_s <= low_left;
          end
        end
        lvts_pkg::S_ID_CHK: begin
          if (id_match) begin
            res.group_index <= 3'(g);
            res.slot_index <= 4'(cur_s);
          end else begin
            left <= left & ~cur_bit;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/leveled_task_slot_table_core.sv
// Top level of the leveled task slot table: configuration register and result register.
//
//  Channel  Signals                                      Direction
//  cfg      cfg_valid / cfg_ready, cfg_data              write total_groups
//  in       in_valid / in_stall, cmd .. delay_word       request in
//  out      out_valid / out_stall, status .. delay_word_out  result out
//
// A request is taken only when the sequencer is idle; tick and delay requests pass from the
// execute state straight to the done state. Add reads the group mask memory group by group
// until one has a free slot or the level runs out. Delete reads each group's mask, reads the
// id of each occupied slot in turn and takes one more scan step when the group holds no
// match. A stalled result holds the sequencer, while the output register frees it for the
// next request. Reset is synchronous and needs no clearing pass.
module leveled_task_slot_table_core #(
  parameter int SLOTS_PER_GROUP = lvts_pkg::SLOTS_PER_GROUP_DEF,
  parameter int LEVEL0_GROUPS = lvts_pkg::LEVEL0_GROUPS_DEF,
  parameter int LEVEL1_GROUPS = lvts_pkg::LEVEL1_GROUPS_DEF,
  parameter int LEVEL2_GROUPS = lvts_pkg::LEVEL2_GROUPS_DEF,
  parameter int LEVEL3_GROUPS = lvts_pkg::LEVEL3_GROUPS_DEF,
  parameter int TASK_ID_BITS = lvts_pkg::TASK_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  level,
  input  logic [15:0] task_id,
  input  logic [15:0] period,
  input  logic [15:0] start_offset,
  input  logic [31:0] delay_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  group_index,
  output logic [3:0]  slot_index,
  output logic [31:0] delay_word_out
);

  logic [3:0]     total_groups;
  logic           res_valid;
  logic           res_ready;
  lvts_pkg::res_t res;
  lvts_pkg::res_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_groups <= lvts_pkg::TOTAL_GROUPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      total_groups <= cfg_data;
    end
  end

  lvts_engine #(
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP),
    .LEVEL0_GROUPS  (LEVEL0_GROUPS),
    .LEVEL1_GROUPS  (LEVEL1_GROUPS),
    .LEVEL2_GROUPS  (LEVEL2_GROUPS),
    .LEVEL3_GROUPS  (LEVEL3_GROUPS),
    .TASK_ID_BITS   (TASK_ID_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .total_groups(total_groups),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .level       (level),
    .task_id     (task_id),
    .period      (period),
    .start_offset(start_offset),
    .delay_word  (delay_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign status = out_res.status;
  assign group_index = out_res.group_index;
  assign slot_index = out_res.slot_index;
  assign delay_word_out = out_res.delay_word;

endmodule

FILE: sv/lvts_checker.sv
// Port-level checks for the leveled task slot table and their binding to the top level.
module lvts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [2:0]  group_index,
  input logic [3:0]  slot_index,
  input logic [31:0] delay_word_out
);

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  // Only one request is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("New request taken while one is in work.");

  // A failed request reports no slot and no delay record.
  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lvts_pkg::ST_OK |->
      group_index == 3'd0 && slot_index == 4'd0 && delay_word_out == 32'd0)
    else $error("Failed request carries slot or delay data.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(status) && $stable(group_index) && $stable(slot_index)
      && $stable(delay_word_out))
    else $error("Stalled result changed.");

endmodule

bind leveled_task_slot_table_core lvts_checker u_lvts_checker (.*);

FILE: tb/sv/leveled_task_slot_table_core_test.sv
// Self-checking testbench for leveled_task_slot_table_core: directed and random requests against a table predictor.
module leveled_task_slot_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = lvts_pkg::SLOTS_PER_GROUP_DEF;
  localparam int GROUPS = lvts_pkg::LEVEL0_GROUPS_DEF + lvts_pkg::LEVEL1_GROUPS_DEF +
                          lvts_pkg::LEVEL2_GROUPS_DEF + lvts_pkg::LEVEL3_GROUPS_DEF;
  localparam logic [2:0] LVL_BAD_FIRST = 3'd4;
  localparam logic [2:0] LVL_BAD_LAST = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 275;

  typedef struct {
    lvts_pkg::cmd_t cmd;
    logic [2:0]  level;
    logic [15:0] task_id;
    logic [15:0] period;
    logic [15:0] start_offset;
    logic [31:0] delay_word;
  } table_request_t;

  typedef struct {
    lvts_pkg::status_t status;
    logic [2:0]  group_index;
    logic [3:0]  slot_index;
    logic [31:0] delay_word;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = 2'd0;
  logic [2:0]  level = 3'd0;
  logic [15:0] task_id = 16'd0;
  logic [15:0] period = 16'd0;
  logic [15:0] start_offset = 16'd0;
  logic [31:0] delay_word = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  group_index;
  logic [3:0]  slot_index;
  logic [31:0] delay_word_out;

  leveled_task_slot_table_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .level(level),
    .task_id(task_id),
    .period(period),
    .start_offset(start_offset),
    .delay_word(delay_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .group_index(group_index),
    .slot_index(slot_index),
    .delay_word_out(delay_word_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted table state.
  logic [15:0]      tick_now = 16'd0;
  logic [3:0]       groups_in_use = lvts_pkg::TOTAL_GROUPS_RST;
  logic [SLOTS-1:0] busy_mask [GROUPS];
  logic [SLOTS-1:0] fresh_mask [GROUPS];
  logic [15:0]      slot_id [GROUPS*SLOTS];
  logic [15:0]      slot_period [GROUPS*SLOTS];
  logic [15:0]      slot_start [GROUPS*SLOTS];

  // Task ids the stimulus expects to be present, per level.
  logic [15:0] planned_ids [4][GROUPS*SLOTS];
  int          planned_count [4];
  int          planned_ticks = 0;

  table_request_t request_backlog [$];
  table_reply_t   table_replies [$];
  table_request_t shown_request;

  int error_count = 0;
  int requests_sent = 0;
  int replies_seen = 0;
  int full_seen = 0;
  int missing_seen = 0;
  int bad_level_seen = 0;
  int done_seen = 0;
  int settings_written = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_run = 0;
  int stall_mode = 0;

  initial begin
    for (int g = 0; g < GROUPS; g++) begin
      busy_mask[g] = '0;
      fresh_mask[g] = '0;
    end
    for (int l = 0; l < 4; l++) begin
      planned_count[l] = 0;
    end
  end

  function automatic bit level_span(input logic [2:0] lv, output int first, output int count);
    first = 0;
    count = 0;
    case (lv)
      lvts_pkg::LVL_3: begin
        count = lvts_pkg::LEVEL3_GROUPS_DEF;
      end
      lvts_pkg::LVL_2: begin
        first = lvts_pkg::LEVEL3_GROUPS_DEF;
        count = lvts_pkg::LEVEL2_GROUPS_DEF;
      end
      lvts_pkg::LVL_1: begin
        first = lvts_pkg::LEVEL3_GROUPS_DEF + lvts_pkg::LEVEL2_GROUPS_DEF;
        count = lvts_pkg::LEVEL1_GROUPS_DEF;
      end
      lvts_pkg::LVL_0: begin
        first = lvts_pkg::LEVEL3_GROUPS_DEF + lvts_pkg::LEVEL2_GROUPS_DEF +
                lvts_pkg::LEVEL1_GROUPS_DEF;
        count = lvts_pkg::LEVEL0_GROUPS_DEF;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic table_reply_t table_apply(input table_request_t r);
    table_reply_t o;
    int first, count, k;
    logic [15:0] lapse;
    bit done;
    o.status = lvts_pkg::ST_OK;
    o.group_index = 3'd0;
    o.slot_index = 4'd0;
    o.delay_word = 32'd0;
    done = 1'b0;
    case (r.cmd)
      lvts_pkg::CMD_TICK: tick_now = tick_now + 16'd1;
      lvts_pkg::CMD_DELAY: begin
        o.delay_word = r.delay_word;
        if ((o.delay_word & lvts_pkg::DLY_STAMP_MASK) == 32'd0) begin
          o.delay_word[31:16] = tick_now;
        end
        lapse = tick_now - o.delay_word[31:16];
        if (32'(lapse) >= (o.delay_word & lvts_pkg::DLY_COUNT_MASK)) begin
          o.delay_word = o.delay_word | lvts_pkg::DLY_DONE_BIT;
        end
      end
      default: begin
        if (!level_span(r.level, first, count)) begin
          o.status = lvts_pkg::ST_BAD_LEVEL;
        end else if (r.cmd == lvts_pkg::CMD_ADD) begin
          o.status = lvts_pkg::ST_FULL;
          for (int g = first; g < first + count && !done; g++) begin
            for (int s = 0; s < SLOTS && !done; s++) begin
              if (!busy_mask[g][s]) begin
                k = g * SLOTS + s;
                if (g < int'(groups_in_use) - lvts_pkg::LEVEL0_GROUPS_DEF) begin
                  fresh_mask[g][s] = 1'b1;
                end
                busy_mask[g][s] = 1'b1;
                slot_id[k] = r.task_id;
                slot_period[k] = r.period;
                slot_start[k] = tick_now + r.start_offset;
                o.status = lvts_pkg::ST_OK;
                o.group_index = 3'(g);
                o.slot_index = 4'(s);
                done = 1'b1;
              end
            end
          end
        end else begin
          o.status = lvts_pkg::ST_NOT_FOUND;
          for (int g = first; g < first + count && !done; g++) begin
            for (int s = 0; s < SLOTS && !done; s++) begin
              if (busy_mask[g][s] && slot_id[g * SLOTS + s] == r.task_id) begin
                busy_mask[g][s] = 1'b0;
                o.status = lvts_pkg::ST_OK;
                o.group_index = 3'(g);
                o.slot_index = 4'(s);
                done = 1'b1;
              end
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic plan_request(input lvts_pkg::cmd_t c, input logic [2:0] lv,
                              input logic [15:0] id, input logic [15:0] per,
                              input logic [15:0] off, input logic [31:0] dw);
    table_request_t r;
    int first, count, n;
    r.cmd = c;
    r.level = lv;
    r.task_id = id;
    r.period = per;
    r.start_offset = off;
    r.delay_word = dw;
    request_backlog.push_back(r);
    if (c == lvts_pkg::CMD_TICK) begin
      planned_ticks++;
    end else if (c != lvts_pkg::CMD_DELAY && level_span(lv, first, count)) begin
      n = planned_count[lv];
      if (c == lvts_pkg::CMD_ADD && n < count * SLOTS) begin
        planned_ids[lv][n] = id;
        planned_count[lv] = n + 1;
      end else if (c == lvts_pkg::CMD_DEL) begin
        for (int j = 0; j < n; j++) begin
          if (planned_ids[lv][j] == id) begin
            planned_ids[lv][j] = planned_ids[lv][n - 1];
            planned_count[lv] = n - 1;
            break;
          end
        end
      end
    end
  endtask

  task automatic random_request(input int add_pct, input bit narrow_ids);
    lvts_pkg::cmd_t c;
    logic [2:0] lv;
    logic [15:0] id;
    logic [31:0] dw;
    int pick, l;
    c = lvts_pkg::CMD_TICK;
    lv = 3'($urandom());
    id = narrow_ids ? 16'($urandom_range(0, 7)) : 16'($urandom());
    dw = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      c = lvts_pkg::CMD_TICK;
    end else if (pick < 24) begin
      c = lvts_pkg::CMD_DELAY;
      case ($urandom_range(0, 2))
        0: begin
          dw[31:16] = 16'd0;
          dw[14:0] = 15'($urandom_range(0, 3));
        end
        1: begin
          dw[31:16] = 16'(planned_ticks - $urandom_range(0, 40));
          dw[14:0] = 15'($urandom_range(0, 48));
        end
        default: begin
        end
      endcase
    end else if (pick < 28) begin
      c = ($urandom_range(0, 1) == 0) ? lvts_pkg::CMD_ADD : lvts_pkg::CMD_DEL;
      lv = 3'($urandom_range(LVL_BAD_FIRST, LVL_BAD_LAST));
    end else begin
      l = $urandom_range(0, 3);
      lv = 3'(l);
      if (pick < 28 + add_pct) begin
        c = lvts_pkg::CMD_ADD;
      end else begin
        c = lvts_pkg::CMD_DEL;
        if (planned_count[l] > 0 && $urandom_range(0, 4) != 0) begin
          id = planned_ids[l][$urandom_range(0, planned_count[l] - 1)];
        end
      end
    end
    plan_request(c, lv, id, 16'($urandom()), 16'($urandom()), dw);
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (request_backlog.size() > 0 || in_valid || table_replies.size() > 0);
  endtask

  task automatic write_groups(input logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    groups_in_use = value;
    settings_written++;
  endtask

  always @(posedge clk) begin : request_driver
    table_request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_replies.push_back(table_apply(shown_request));
        requests_sent++;
      end
      if (in_valid && in_stall) begin
        // The request stays on the port until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        r = request_backlog.pop_front();
        shown_request = r;
        in_valid <= 1'b1;
        cmd <= r.cmd;
        level <= r.level;
        task_id <= r.task_id;
        period <= r.period;
        start_offset <= r.start_offset;
        delay_word <= r.delay_word;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
          end else if ($urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(6, 14);
          end else begin
            gap_left = $urandom_range(1, 3);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    table_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (table_replies.size() == 0) begin
          $error("result arrived with no request outstanding");
          error_count++;
        end else begin
          want = table_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), status);
            error_count++;
          end
          if (group_index !== want.group_index) begin
            $error("group_index: expected %0d, got %0d", want.group_index, group_index);
            error_count++;
          end
          if (slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
            error_count++;
          end
          if (delay_word_out !== want.delay_word) begin
            $error("delay_word_out: expected %h, got %h", want.delay_word, delay_word_out);
            error_count++;
          end
          case (want.status)
            lvts_pkg::ST_FULL: full_seen++;
            lvts_pkg::ST_NOT_FOUND: missing_seen++;
            lvts_pkg::ST_BAD_LEVEL: bad_level_seen++;
            default: begin
            end
          endcase
          if ((want.delay_word & lvts_pkg::DLY_DONE_BIT) != 32'd0) begin
            done_seen++;
          end
        end
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(20, 200);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ((stall_run % 16) < 10);
      endcase
    end
  end

  initial begin : timeout
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] settings [PHASES];
    int add_share [PHASES];
    settings = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd9};
    add_share = '{55, 30, 60, 20, 40, 35};
    settings[4] = 4'($urandom_range(2, 7));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(negedge clk);
    end while (rst);

    plan_request(lvts_pkg::CMD_DELAY, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000,
                 32'h0000_0000);
    plan_request(lvts_pkg::CMD_DELAY, LVL_BAD_LAST, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 lvts_pkg::DLY_COUNT_MASK);
    repeat (3) plan_request(lvts_pkg::CMD_TICK, LVL_BAD_LAST, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            '1);
    plan_request(lvts_pkg::CMD_DELAY, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000,
                 32'hFFFF_FFFF);
    plan_request(lvts_pkg::CMD_DELAY, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000,
                 32'h0000_0002);
    plan_request(lvts_pkg::CMD_DELAY, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000,
                 {16'h0001, 1'b0, 15'd2});
    plan_request(lvts_pkg::CMD_DELAY, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000,
                 {16'hFFF0, 1'b0, 15'd32});
    plan_request(lvts_pkg::CMD_ADD, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'hFFFF, 32'h0);
    plan_request(lvts_pkg::CMD_ADD, lvts_pkg::LVL_1, 16'hFFFF, 16'hFFFF, 16'h0000, '1);
    plan_request(lvts_pkg::CMD_ADD, lvts_pkg::LVL_2, 16'h5A5A, 16'h00FF, 16'h8000, 32'h0);
    plan_request(lvts_pkg::CMD_ADD, lvts_pkg::LVL_3, 16'hA5A5, 16'hFF00, 16'h7FFF, 32'h0);
    plan_request(lvts_pkg::CMD_ADD, lvts_pkg::LVL_3, 16'hA5A5, 16'h1234, 16'h0001, 32'h0);
    for (int v = LVL_BAD_FIRST; v <= LVL_BAD_LAST; v++) begin
      plan_request((v % 2 == 0) ? lvts_pkg::CMD_ADD : lvts_pkg::CMD_DEL, 3'(v), 16'h0000,
                   16'h0, 16'h0, 32'h0);
    end
    plan_request(lvts_pkg::CMD_DEL, lvts_pkg::LVL_0, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    plan_request(lvts_pkg::CMD_DEL, lvts_pkg::LVL_1, 16'h1234, 16'h0000, 16'h0000, 32'h0);
    plan_request(lvts_pkg::CMD_DEL, lvts_pkg::LVL_3, 16'hA5A5, 16'h0000, 16'h0000, 32'h0);
    plan_request(lvts_pkg::CMD_DEL, lvts_pkg::LVL_2, 16'hFFFF, 16'h0000, 16'h0000, 32'h0);
    plan_request(lvts_pkg::CMD_DEL, lvts_pkg::LVL_1, 16'hFFFF, 16'h0000, 16'h0000, 32'h0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_groups(settings[p]);
      repeat (PHASE_REQUESTS) random_request(add_share[p], p % 2 == 1);
      wait_idle();
    end
    repeat (12) @(posedge clk);

    $display("Ran %0d requests under %0d group settings; %0d results checked.",
             requests_sent, settings_written, replies_seen);
    $display("Seen: %0d level full, %0d id not found, %0d bad level, %0d delays done.",
             full_seen, missing_seen, bad_level_seen, done_seen);
    if (error_count == 0 && table_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
